// ----- design/sbalu_pkg.sv -----
`timescale 1ns / 1ps

package sbalu_pkg;

  localparam int DATA_W      = 8;
  localparam int CMD_W       = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MOD = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     divide_by_zero;
  } out_t;

  // classified beat handed from front to back
  typedef struct packed {
    cmd_e              cmd;
    logic              neg;
    logic              dz;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] ma;
    logic [DATA_W-1:0] mb;
  } item_t;

endpackage

// ----- design/sbalu_front.sv -----
`timescale 1ns / 1ps

module sbalu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sbalu_pkg::in_t  in_data,
  output logic            item_valid,
  input  logic            item_ready,
  output sbalu_pkg::item_t item
);

  localparam int W = sbalu_pkg::DATA_W;

  sbalu_pkg::item_t item_next;
  logic             a_neg;
  logic             b_neg;
  logic [W-1:0]     mb;

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    return x[W-1] ? W'(~x + 1'b1) : x;
  endfunction

  assign a_neg    = in_data.operand_a[W-1];
  assign b_neg    = in_data.operand_b[W-1];
  assign mb       = mag(in_data.operand_b);
  assign in_ready = !item_valid || item_ready;

  always_comb begin
    item_next     = '0;
    item_next.cmd = sbalu_pkg::cmd_e'(in_data.cmd);
    item_next.a   = in_data.operand_a;
    item_next.b   = in_data.operand_b;
    item_next.ma  = mag(in_data.operand_a);
    item_next.mb  = mb;
    unique case (sbalu_pkg::cmd_e'(in_data.cmd))
      sbalu_pkg::CMD_MUL: begin
        item_next.neg = a_neg ^ b_neg;
      end
      sbalu_pkg::CMD_DIV: begin
        item_next.neg = a_neg ^ b_neg;
        item_next.dz  = (mb == '0);
      end
      sbalu_pkg::CMD_MOD: begin
        item_next.dz  = (mb == '0);
      end
      default: begin
        item_next.neg = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

// ----- design/sbalu_queue.sv -----
`timescale 1ns / 1ps

module sbalu_queue #(
  parameter int DEPTH = sbalu_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  sbalu_pkg::item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output sbalu_pkg::item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sbalu_pkg::item_t mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- design/sbalu_back.sv -----
`timescale 1ns / 1ps

module sbalu_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sbalu_pkg::item_t item,
  output logic             out_valid,
  input  logic             out_ready,
  output sbalu_pkg::out_t  out_data
);

  localparam int W  = sbalu_pkg::DATA_W;
  localparam int NS = sbalu_pkg::DATA_W;

  typedef struct packed {
    sbalu_pkg::cmd_e cmd;
    logic            neg;
    logic            dz;
    logic [W-1:0]    a;
    logic [W-1:0]    b;
    logic [W-1:0]    mb;
    logic [W-1:0]    rem;
    logic [W-1:0]    quo;
    logic [W-1:0]    prod;
  } stage_t;

  stage_t        st [NS+1];
  stage_t        st0_next;
  logic [NS:0]   vld;
  logic          en;

  function automatic logic [W-1:0] negate_if(input logic [W-1:0] v, input logic neg);
    return neg ? W'(~v + 1'b1) : v;
  endfunction

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic stage_t div_step(input stage_t s);
    stage_t       r;
    logic [W-1:0] trial;
    logic         take;
    r     = s;
    trial = {s.rem[W-2:0], s.quo[W-1]};
    take  = (trial >= s.mb);
    r.rem = take ? W'(trial - s.mb) : trial;
    r.quo = {s.quo[W-2:0], take};
    return r;
  endfunction

  function automatic sbalu_pkg::out_t finish(input stage_t s);
    sbalu_pkg::out_t o;
    o                = '0;
    o.divide_by_zero = s.dz;
    unique case (s.cmd)
      sbalu_pkg::CMD_ADD: o.result_value = W'(s.a + s.b);
      sbalu_pkg::CMD_SUB: o.result_value = W'(s.a - s.b);
      sbalu_pkg::CMD_MUL: o.result_value = negate_if(s.prod, s.neg);
      sbalu_pkg::CMD_DIV: o.result_value = negate_if(s.quo, s.neg);
      sbalu_pkg::CMD_MOD: o.result_value = s.rem;
      default:            o.result_value = '0;
    endcase
    return o;
  endfunction

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    st0_next      = '0;
    st0_next.cmd  = item.cmd;
    st0_next.neg  = item.neg;
    st0_next.dz   = item.dz;
    st0_next.a    = item.a;
    st0_next.b    = item.b;
    st0_next.mb   = item.mb;
    st0_next.rem  = '0;
    st0_next.quo  = item.ma;
    st0_next.prod = W'(item.ma * item.mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NS-1:0], in_valid};
      out_valid <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= st0_next;
      for (int k = 1; k <= NS; k++) begin
        st[k] <= div_step(st[k-1]);
      end
      out_data <= finish(st[NS]);
    end
  end

endmodule

// ----- design/signed_byte_alu_mul_div_top.sv -----
// an input beat passes the front register, the queue, the divider stages and the output register
// throughput: one beat per cycle while the output is not stalled; the divider is one restoring step per pipeline stage
// the front register and the queue absorb a stalled back end, which freezes as a whole
// reset: synchronous, clears all valid bits, queue pointers and counts
// after reset in_ready is high, so the block takes a beat straight away
`timescale 1ns / 1ps

module signed_byte_alu_mul_div_top #(
  parameter int QUEUE_DEPTH = sbalu_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sbalu_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sbalu_pkg::out_t out_data
);

  sbalu_pkg::item_t fr_item;
  sbalu_pkg::item_t q_item;
  logic             fr_valid;
  logic             fr_ready;
  logic             q_valid;
  logic             q_ready;

  sbalu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (fr_valid),
    .item_ready (fr_ready),
    .item       (fr_item)
  );

  sbalu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  sbalu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .item      (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- design/sbalu_checker.sv -----
`timescale 1ns / 1ps

module sbalu_checker #(
  parameter int MAX_INFLIGHT = 1 + sbalu_pkg::QUEUE_DEPTH + sbalu_pkg::DATA_W + 2
) (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input sbalu_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input sbalu_pkg::out_t out_data
);

  localparam int CW = $clog2(MAX_INFLIGHT + 2);

  logic [CW-1:0] inflight;
  logic          in_acc;
  logic          out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (in_acc && !out_acc) begin
      inflight <= CW'(inflight + 1'b1);
    end else if (out_acc && !in_acc) begin
      inflight <= CW'(inflight - 1'b1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("result beat without an outstanding input beat");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    inflight <= CW'(MAX_INFLIGHT))
    else $error("more beats in flight than the pipeline holds");

  a_data_known: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> !$isunknown(in_data))
    else $error("input beat accepted with unknown payload");

endmodule

bind signed_byte_alu_mul_div_top sbalu_checker #(
  .MAX_INFLIGHT (1 + QUEUE_DEPTH + sbalu_pkg::DATA_W + 2)
) u_sbalu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int DW             = sbalu_pkg::DATA_W;
  localparam int CW             = sbalu_pkg::CMD_W;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 30;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  sbalu_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  sbalu_pkg::out_t out_data;

  sbalu_pkg::out_t pending_results[$];
  int   errors      = 0;
  int   checked     = 0;
  int   dz_seen     = 0;
  int   idle_cycles = 0;
  int   stall_left  = 0;
  int   op_count[2**CW];
  bit   idle_on     = 1'b1;
  bit   stall_on    = 1'b1;

  always #5 clk = ~clk;

  signed_byte_alu_mul_div_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic int pick_operand();
    unique case ($urandom_range(0, 5))
      0: return -128;
      1: return -1;
      2: return 0;
      3: return 1;
      4: return 127;
      default: return $urandom;
    endcase
  endfunction

  // magnitudes are twice as wide as the operands so that -128 maps to 128
  function automatic sbalu_pkg::out_t alu_result(sbalu_pkg::in_t item);
    logic [2*DW-1:0] mag_a;
    logic [2*DW-1:0] mag_b;
    logic [2*DW-1:0] raw;
    logic            flip;
    sbalu_pkg::out_t res;
    mag_a = {{DW{1'b0}}, item.operand_a};
    mag_b = {{DW{1'b0}}, item.operand_b};
    if (item.operand_a[DW-1]) mag_a = {{DW{1'b0}}, -item.operand_a};
    if (item.operand_b[DW-1]) mag_b = {{DW{1'b0}}, -item.operand_b};
    flip = item.operand_a[DW-1] ^ item.operand_b[DW-1];
    res  = '0;
    unique case (item.cmd)
      sbalu_pkg::CMD_ADD: res.result_value = item.operand_a + item.operand_b;
      sbalu_pkg::CMD_SUB: res.result_value = item.operand_a - item.operand_b;
      sbalu_pkg::CMD_MUL: begin
        raw = mag_a * mag_b;
        res.result_value = flip ? -raw[DW-1:0] : raw[DW-1:0];
      end
      sbalu_pkg::CMD_DIV: begin
        if (mag_b == 0) begin
          res.divide_by_zero = 1'b1;
          res.result_value   = item.operand_a[DW-1] ? {{(DW-1){1'b0}}, 1'b1}
                                                    : {DW{1'b1}};
        end else begin
          raw = mag_a / mag_b;
          res.result_value = flip ? -raw[DW-1:0] : raw[DW-1:0];
        end
      end
      sbalu_pkg::CMD_MOD: begin
        if (mag_b == 0) begin
          res.divide_by_zero = 1'b1;
          res.result_value   = mag_a[DW-1:0];
        end else begin
          raw = mag_a % mag_b;
          res.result_value = raw[DW-1:0];
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  task automatic push_op(input int cmd, input int a, input int b);
    sbalu_pkg::in_t item;
    int             gap;
    item.cmd       = CW'(cmd);
    item.operand_a = DW'(a);
    item.operand_b = DW'(b);
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(alu_result(item));
    op_count[item.cmd]++;
  endtask

  task automatic test_directed();
    push_op(sbalu_pkg::CMD_ADD, 127, 1);
    push_op(sbalu_pkg::CMD_ADD, -128, -1);
    push_op(sbalu_pkg::CMD_SUB, -128, 1);
    push_op(sbalu_pkg::CMD_SUB, 127, -1);
    push_op(sbalu_pkg::CMD_MUL, -128, -1);
    push_op(sbalu_pkg::CMD_MUL, -128, -128);
    push_op(sbalu_pkg::CMD_MUL, 127, 127);
    push_op(sbalu_pkg::CMD_MUL, -1, 127);
    push_op(sbalu_pkg::CMD_MUL, 0, -128);
    push_op(sbalu_pkg::CMD_DIV, -128, -1);
    push_op(sbalu_pkg::CMD_DIV, -128, 1);
    push_op(sbalu_pkg::CMD_DIV, 127, -128);
    push_op(sbalu_pkg::CMD_DIV, 7, -2);
    push_op(sbalu_pkg::CMD_DIV, -7, 2);
    push_op(sbalu_pkg::CMD_DIV, 100, 0);
    push_op(sbalu_pkg::CMD_DIV, -100, 0);
    push_op(sbalu_pkg::CMD_DIV, -128, 0);
    push_op(sbalu_pkg::CMD_MOD, -128, 3);
    push_op(sbalu_pkg::CMD_MOD, 7, -3);
    push_op(sbalu_pkg::CMD_MOD, -128, 0);
    push_op(sbalu_pkg::CMD_MOD, 127, 0);
    push_op(sbalu_pkg::CMD_MOD, -5, -128);
    for (int c = sbalu_pkg::CMD_MOD + 1; c < 2**CW; c++) push_op(c, -1, -1);
  endtask

  task automatic test_random_ops();
    for (int i = 0; i < 300; i++) push_op($urandom_range(0, 2**CW - 1), $urandom, $urandom);
  endtask

  task automatic test_corner_operands();
    for (int i = 0; i < 150; i++) begin
      push_op($urandom_range(sbalu_pkg::CMD_ADD, sbalu_pkg::CMD_MOD), pick_operand(),
              pick_operand());
    end
  endtask

  task automatic test_back_to_back();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    for (int i = 0; i < 60; i++) push_op($urandom_range(0, 2**CW - 1), $urandom, $urandom);
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // output side stalls: alternating ready runs and stall runs
  always @(posedge clk) begin
    if (rst || !stall_on) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= ~out_ready;
      stall_left <= out_ready ? pick_gap() : $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin : check_results
    sbalu_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual %h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_value !== want.result_value) begin
          errors++;
          $display("%0t: result_value expected %h actual %h", $time, want.result_value,
                   out_data.result_value);
        end
        if (out_data.divide_by_zero !== want.divide_by_zero) begin
          errors++;
          $display("%0t: divide_by_zero expected %b actual %b", $time, want.divide_by_zero,
                   out_data.divide_by_zero);
        end
        checked++;
        dz_seen += want.divide_by_zero;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_ops();
    test_corner_operands();
    test_back_to_back();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent add %0d, sub %0d, mul %0d, div %0d, mod %0d, unused codes %0d",
             op_count[sbalu_pkg::CMD_ADD], op_count[sbalu_pkg::CMD_SUB],
             op_count[sbalu_pkg::CMD_MUL], op_count[sbalu_pkg::CMD_DIV],
             op_count[sbalu_pkg::CMD_MOD], op_count[5] + op_count[6] + op_count[7]);
    $display("%0d results checked, %0d of them divide by zero", checked, dz_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
